>>> design/ptclk_pkg.sv
// ----------------------------------------------------------------------------
// ptclk_pkg: playback transport clock package
// Transaction types and command codes shared by the transport clock files.
// ----------------------------------------------------------------------------
package ptclk_pkg;

    localparam logic [1:0] FUNC_PLAY   = 2'd0;
    localparam logic [1:0] FUNC_PAUSE  = 2'd1;
    localparam logic [1:0] FUNC_ADJUST = 2'd2;

    localparam logic [63:0] ALL64 = '1;
    localparam logic [31:0] ALL32 = '1;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] now;
        logic        has_tempo;
        logic [31:0] new_step_micros;
        logic        has_seek;
        logic [31:0] seek_step;
        logic        has_loop;
        logic        new_loop;
        logic [15:0] song_steps;
    } cmd_t;

    typedef struct packed {
        logic [63:0] start_out;
        logic [31:0] step_micros_out;
        logic        paused_out;
        logic [31:0] paused_step_out;
        logic        loop_out;
    } rsp_t;

endpackage

>>> design/playback_transport_clock.sv
// ----------------------------------------------------------------------------
// playback_transport_clock
// Transport state of a step-based player, updated by play/pause/adjust.
// ----------------------------------------------------------------------------
// One command transaction is taken at a time; cmd_ready is low from accept
// until its response transaction is taken. All long arithmetic runs through
// one shared 32x32 multiplier and one restoring divider that retires one
// quotient bit per cycle. Plain commands go straight to the response; a seek
// or play adds one multiply, a pause while playing a 64-bit divide, and a
// retime while playing two partial products, then a 96-bit divide. A loop
// realignment (modulo the song duration) runs first when it is needed, and
// a zero duration skips its divide. The response shows the state registers
// directly and holds until taken.
// ----------------------------------------------------------------------------
module playback_transport_clock #(
    parameter logic [31:0] DEFAULT_STEP_MICROS = 32'd500000
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  ptclk_pkg::cmd_t cmd,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output ptclk_pkg::rsp_t rsp
);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOOP = 4'd1;   // dur = step * song into multiplier
    localparam logic [3:0] S_LCHK = 4'd2;   // start modulo divide if dur != 0
    localparam logic [3:0] S_CMD  = 4'd3;   // decode command
    localparam logic [3:0] S_DIV  = 4'd4;   // one quotient bit per cycle
    localparam logic [3:0] S_FIN  = 4'd5;   // consume divider result
    localparam logic [3:0] S_RM1  = 4'd6;   // low partial product
    localparam logic [3:0] S_RM2  = 4'd7;   // high partial product
    localparam logic [3:0] S_RM3  = 4'd8;   // combine, start 96-bit divide
    localparam logic [3:0] S_SMUL = 4'd9;   // step index * step length
    localparam logic [3:0] S_SSUB = 4'd10;  // start = now - product
    localparam logic [3:0] S_OUT  = 4'd11;

    // what the divider or multiplier result is for
    localparam logic [1:0] OP_LOOP   = 2'd0;
    localparam logic [1:0] OP_PAUSE  = 2'd1;
    localparam logic [1:0] OP_RETIME = 2'd2;
    localparam logic [1:0] OP_SEEK   = 2'd3;
    localparam logic [1:0] OP_PLAY   = OP_PAUSE;  // multiply path only

    localparam logic [6:0] DIV64 = 7'd64;
    localparam logic [6:0] DIV96 = 7'd96;

    logic [3:0]  state_reg, state_next;
    logic [63:0] start_reg, start_next;
    logic [31:0] step_reg, step_next;
    logic        paused_reg, paused_next;
    logic [31:0] ps_reg, ps_next;
    logic        loop_reg, loop_next;

    ptclk_pkg::cmd_t cmd_reg, cmd_next;
    logic [63:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;
    logic [95:0] quo_reg, quo_next;
    logic [47:0] rem_reg, rem_next;
    logic [47:0] div_reg, div_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [1:0]  op_reg, op_next;
    logic [63:0] mul_reg;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    // divider step
    logic [48:0] rem_sh;
    logic        div_ge;
    logic [48:0] rem_sub;

    logic [63:0] pos;
    logic [63:0] quot;
    logic        loop_go;

    assign pos     = cmd_reg.now - start_reg;
    assign quot    = quo_reg[63:0];
    assign rem_sh  = {rem_reg, quo_reg[95]};
    assign div_ge  = rem_sh >= {1'b0, div_reg};
    assign rem_sub = rem_sh - {1'b0, div_reg};
    assign loop_go = cmd_reg.has_loop && !paused_reg && loop_reg && !cmd_reg.new_loop
                     && (cmd_reg.song_steps != 16'd0);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_LOOP:
            begin
                mul_a = step_reg;
                mul_b = {16'd0, cmd_reg.song_steps};
            end
            S_RM1:
            begin
                mul_a = mag_reg[31:0];
                mul_b = cmd_reg.new_step_micros;
            end
            S_RM2:
            begin
                mul_a = mag_reg[63:32];
                mul_b = cmd_reg.new_step_micros;
            end
            S_SMUL:
            begin
                mul_a = (op_reg == OP_SEEK) ? cmd_reg.seek_step : ps_reg;
                mul_b = step_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    always_comb
    begin
        state_next  = state_reg;
        start_next  = start_reg;
        step_next   = step_reg;
        paused_next = paused_reg;
        ps_next     = ps_reg;
        loop_next   = loop_reg;
        cmd_next    = cmd_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        cnt_next    = cnt_reg;
        op_next     = op_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                if (loop_go)
                    state_next = S_LCHK;
                else
                begin
                    if (cmd_reg.has_loop)
                        loop_next = cmd_reg.new_loop;
                    state_next = S_CMD;
                end
            end
            S_LCHK:
            begin
                if (mul_reg[47:0] == 48'd0)
                begin
                    loop_next  = cmd_reg.new_loop;
                    state_next = S_CMD;
                end
                else
                begin
                    quo_next   = {pos, 32'd0};
                    rem_next   = '0;
                    div_next   = mul_reg[47:0];
                    cnt_next   = DIV64;
                    op_next    = OP_LOOP;
                    state_next = S_DIV;
                end
            end
            S_CMD:
            begin
                state_next = S_OUT;
                case (cmd_reg.func)
                    ptclk_pkg::FUNC_PLAY:
                    begin
                        if (paused_reg)
                        begin
                            if (cmd_reg.has_tempo)
                                step_next = cmd_reg.new_step_micros;
                            if (cmd_reg.has_seek)
                                ps_next = cmd_reg.seek_step;
                            op_next    = OP_PLAY;
                            state_next = S_SMUL;
                        end
                    end
                    ptclk_pkg::FUNC_PAUSE:
                    begin
                        if (!paused_reg && step_reg != 32'd0 && start_reg < cmd_reg.now)
                        begin
                            quo_next   = {pos, 32'd0};
                            rem_next   = '0;
                            div_next   = {16'd0, step_reg};
                            cnt_next   = DIV64;
                            op_next    = OP_PAUSE;
                            state_next = S_DIV;
                        end
                        else
                        begin
                            if (!paused_reg)
                            begin
                                ps_next    = '0;
                                start_next = ptclk_pkg::ALL64;
                            end
                            paused_next = 1'b1;
                            if (cmd_reg.has_tempo)
                                step_next = cmd_reg.new_step_micros;
                            if (cmd_reg.has_seek)
                                ps_next = cmd_reg.seek_step;
                        end
                    end
                    ptclk_pkg::FUNC_ADJUST:
                    begin
                        if (cmd_reg.has_tempo && !cmd_reg.has_seek && !paused_reg)
                        begin
                            if (step_reg == 32'd0)
                            begin
                                start_next = cmd_reg.now;
                                step_next  = cmd_reg.new_step_micros;
                            end
                            else
                            begin
                                neg_next   = pos[63];
                                mag_next   = pos[63] ? (~pos + 64'd1) : pos;
                                state_next = S_RM1;
                            end
                        end
                        else
                        begin
                            if (cmd_reg.has_tempo)
                                step_next = cmd_reg.new_step_micros;
                            if (cmd_reg.has_seek)
                            begin
                                if (paused_reg)
                                    ps_next = cmd_reg.seek_step;
                                else
                                begin
                                    op_next    = OP_SEEK;
                                    state_next = S_SMUL;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_DIV:
            begin
                quo_next = {quo_reg[94:0], div_ge};
                rem_next = div_ge ? rem_sub[47:0] : rem_sh[47:0];
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_OUT;
                case (op_reg)
                    OP_LOOP:
                    begin
                        start_next = cmd_reg.now - {16'd0, rem_reg};
                        loop_next  = cmd_reg.new_loop;
                        state_next = S_CMD;
                    end
                    OP_PAUSE:
                    begin
                        ps_next     = (quot[63:32] != 32'd0) ? ptclk_pkg::ALL32 : quot[31:0];
                        start_next  = ptclk_pkg::ALL64;
                        paused_next = 1'b1;
                        if (cmd_reg.has_tempo)
                            step_next = cmd_reg.new_step_micros;
                        if (cmd_reg.has_seek)
                            ps_next = cmd_reg.seek_step;
                    end
                    default:
                    begin
                        // retime: round the new position up
                        if (neg_reg)
                            start_next = cmd_reg.now + quot;
                        else
                            start_next = cmd_reg.now - quot - {63'd0, rem_reg != 48'd0};
                        step_next = cmd_reg.new_step_micros;
                    end
                endcase
            end
            S_RM1:
            begin
                state_next = S_RM2;
            end
            S_RM2:
            begin
                quo_next   = {32'd0, mul_reg};
                state_next = S_RM3;
            end
            S_RM3:
            begin
                quo_next   = quo_reg + {mul_reg, 32'd0};
                rem_next   = '0;
                div_next   = {16'd0, step_reg};
                cnt_next   = DIV96;
                op_next    = OP_RETIME;
                state_next = S_DIV;
            end
            S_SMUL:
            begin
                state_next = S_SSUB;
            end
            S_SSUB:
            begin
                start_next = cmd_reg.now - mul_reg;
                if (op_reg != OP_SEEK)
                begin
                    ps_next     = ptclk_pkg::ALL32;
                    paused_next = 1'b0;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (rsp_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            start_reg  <= ptclk_pkg::ALL64;
            step_reg   <= DEFAULT_STEP_MICROS;
            paused_reg <= 1'b1;
            ps_reg     <= '0;
            loop_reg   <= 1'b0;
            cnt_reg    <= '0;
            op_reg     <= OP_LOOP;
        end
        else
        begin
            state_reg  <= state_next;
            start_reg  <= start_next;
            step_reg   <= step_next;
            paused_reg <= paused_next;
            ps_reg     <= ps_next;
            loop_reg   <= loop_next;
            cnt_reg    <= cnt_next;
            op_reg     <= op_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        mul_reg <= mul_p;
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);

    assign rsp.start_out       = start_reg;
    assign rsp.step_micros_out = step_reg;
    assign rsp.paused_out      = paused_reg;
    assign rsp.paused_step_out = ps_reg;
    assign rsp.loop_out        = loop_reg;

endmodule

>>> design/ptclk_checker.sv
// ----------------------------------------------------------------------------
// ptclk_checker
// Port-level checks for the playback transport clock, bound to the top level.
// ----------------------------------------------------------------------------
module ptclk_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            cmd_valid,
    input logic            cmd_ready,
    input ptclk_pkg::cmd_t cmd,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input ptclk_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("ready while command in flight");

    a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !cmd_ready)
        else $error("ready while response pending");

    a_paused_start: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.paused_out |-> rsp.start_out == ptclk_pkg::ALL64)
        else $error("paused with a start time");

    a_playing_step: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.paused_out |-> rsp.paused_step_out == ptclk_pkg::ALL32)
        else $error("playing with a held step");

endmodule

bind playback_transport_clock ptclk_checker u_ptclk_checker (.*);

>>> bench/ptclk_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptclk_scoreboard: transport clock scoreboard
// Watches both channels, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module ptclk_scoreboard #(
    parameter logic [31:0] DEFAULT_STEP_MICROS = 32'd500000
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  logic            cmd_ready,
    input  ptclk_pkg::cmd_t cmd,
    input  logic            rsp_valid,
    input  logic            rsp_ready,
    input  ptclk_pkg::rsp_t rsp,
    output int              fail_count,
    output int              pending_count
);

    logic [63:0] t_start;
    logic [31:0] t_step;
    logic        t_paused;
    logic [31:0] t_held;
    logic        t_loop;

    ptclk_pkg::rsp_t state_q[$];

    assign pending_count = state_q.size();

    function automatic void seek_to(logic [63:0] now, logic [31:0] target);
        if (t_paused)
            t_held = target;
        else
            t_start = now - 64'(target) * 64'(t_step);
    endfunction

    // start = now - ceil(pos*new/old), pos read as signed
    function automatic void retime(logic [63:0] now, logic [31:0] nstep);
        logic [63:0]  pos;
        logic         neg;
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [127:0] quo;
        logic [127:0] rem;
        pos = now - t_start;
        neg = pos[63];
        mag = neg ? -pos : pos;
        if (t_step == 0)
        begin
            t_start = now;
            return;
        end
        prod = 128'(mag) * 128'(nstep);
        quo = prod / 128'(t_step);
        rem = prod % 128'(t_step);
        if (neg)
            t_start = now + quo[63:0];
        else
            t_start = now - (quo[63:0] + ((rem != 0) ? 64'd1 : 64'd0));
    endfunction

    function automatic ptclk_pkg::rsp_t apply_command(ptclk_pkg::cmd_t c);
        logic [63:0] dur;
        logic [63:0] idx;
        ptclk_pkg::rsp_t r;
        if (c.has_loop)
        begin
            dur = 64'(t_step) * 64'(c.song_steps);
            if (!t_paused && t_loop && !c.new_loop && dur != 0)
                t_start = c.now - ((c.now - t_start) % dur);
            t_loop = c.new_loop;
        end
        case (c.func)
            ptclk_pkg::FUNC_PLAY:
            begin
                if (t_paused)
                begin
                    if (c.has_tempo) t_step = c.new_step_micros;
                    if (c.has_seek) seek_to(c.now, c.seek_step);
                    t_start = c.now - 64'(t_held) * 64'(t_step);
                    t_held = ptclk_pkg::ALL32;
                    t_paused = 1'b0;
                end
            end
            ptclk_pkg::FUNC_PAUSE:
            begin
                if (!t_paused)
                begin
                    idx = '0;
                    if (t_step != 0 && t_start < c.now)
                    begin
                        idx = (c.now - t_start) / 64'(t_step);
                        if (idx > 64'(ptclk_pkg::ALL32)) idx = 64'(ptclk_pkg::ALL32);
                    end
                    t_held = idx[31:0];
                    t_start = ptclk_pkg::ALL64;
                    t_paused = 1'b1;
                end
                if (c.has_tempo) t_step = c.new_step_micros;
                if (c.has_seek) seek_to(c.now, c.seek_step);
            end
            ptclk_pkg::FUNC_ADJUST:
            begin
                if (c.has_tempo)
                begin
                    if (!c.has_seek && !t_paused) retime(c.now, c.new_step_micros);
                    t_step = c.new_step_micros;
                end
                if (c.has_seek) seek_to(c.now, c.seek_step);
            end
            default: ;
        endcase
        r.start_out = t_start;
        r.step_micros_out = t_step;
        r.paused_out = t_paused;
        r.paused_step_out = t_held;
        r.loop_out = t_loop;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ptclk_pkg::rsp_t e;
        if (!rst_n)
        begin
            t_start = ptclk_pkg::ALL64;
            t_step = DEFAULT_STEP_MICROS;
            t_paused = 1'b1;
            t_held = '0;
            t_loop = 1'b0;
            state_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
                state_q.push_back(apply_command(cmd));
            if (rsp_valid && rsp_ready)
            begin
                if (state_q.size() == 0)
                begin
                    $error("response with nothing expected");
                    fail_count++;
                end
                else
                begin
                    e = state_q.pop_front();
                    if (rsp.start_out !== e.start_out)
                    begin
                        $error("start_out exp %h got %h", e.start_out, rsp.start_out);
                        fail_count++;
                    end
                    if (rsp.step_micros_out !== e.step_micros_out)
                    begin
                        $error("step_micros_out exp %h got %h",
                               e.step_micros_out, rsp.step_micros_out);
                        fail_count++;
                    end
                    if (rsp.paused_out !== e.paused_out)
                    begin
                        $error("paused_out exp %b got %b", e.paused_out, rsp.paused_out);
                        fail_count++;
                    end
                    if (rsp.paused_step_out !== e.paused_step_out)
                    begin
                        $error("paused_step_out exp %h got %h",
                               e.paused_step_out, rsp.paused_step_out);
                        fail_count++;
                    end
                    if (rsp.loop_out !== e.loop_out)
                    begin
                        $error("loop_out exp %b got %b", e.loop_out, rsp.loop_out);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

>>> bench/tb_playback_transport_clock.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_playback_transport_clock: transport clock testbench
// Directed corner commands then random play/pause/adjust traffic with
// random idling on both channels; the scoreboard checks every response.
// ----------------------------------------------------------------------------
module tb_playback_transport_clock;

    localparam int RANDOM_CMDS = 1030;
    localparam int WATCHDOG    = 20000;   // no-accept cycles before giving up
    localparam int DRAIN_WAIT  = 250;     // longer than the longest command path

    // command code with no defined action
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    ptclk_pkg::cmd_t cmd = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    ptclk_pkg::rsp_t rsp;
    int   fail_count;
    int   pending_count;
    int   idle_cycles = 0;
    int   cmds_sent = 0;
    int   rsps_seen = 0;
    logic stim_done = 1'b0;

    // tracked "now" so most traffic looks like a moving network clock
    logic [63:0] clock_now = 64'd1000;

    always #5 clk = ~clk;

    playback_transport_clock dut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    ptclk_scoreboard chk (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // mostly short gaps, occasionally long ones, sometimes none at all
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // watchdog: counts cycles with no accepted transaction on either channel
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rsp_valid && rsp_ready)
            rsps_seen <= rsps_seen + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG);
            $display("playback_transport_clock verification failed");
            $finish;
        end
    end

    // response side: random stalls, lowered/raised only at falling edges
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            g = gap_len();
            if (g == 0)
            begin
                rsp_ready <= 1'b1;
            end
            else
            begin
                rsp_ready <= 1'b0;
                repeat (g - 1) @(negedge clk);
            end
        end
    end

    // leaves valid high on return; the caller drops it or sends the next one
    task automatic send(ptclk_pkg::cmd_t c);
        cmd <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        cmds_sent++;
        @(negedge clk);
    endtask

    task automatic send_gapped(ptclk_pkg::cmd_t c);
        int g;
        send(c);
        g = gap_len();
        if (g > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    // stop sending until every expected response has come back
    task automatic drain();
        cmd_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
    endtask

    function automatic ptclk_pkg::cmd_t make_cmd(logic [1:0] f, logic [63:0] now);
        ptclk_pkg::cmd_t c;
        c = '0;
        c.func = f;
        c.now = now;
        c.song_steps = 16'd8;
        return c;
    endfunction

    // random command; mostly realistic, sometimes full-range noise
    function automatic ptclk_pkg::cmd_t random_cmd();
        ptclk_pkg::cmd_t c;
        int p;
        p = $urandom_range(0, 99);
        c.func = ($urandom_range(0, 19) == 0) ? FUNC_UNUSED : 2'($urandom_range(0, 2));
        c.has_tempo = $urandom_range(0, 2) == 0;
        c.has_seek = $urandom_range(0, 3) == 0;
        c.has_loop = $urandom_range(0, 2) == 0;
        c.new_loop = 1'($urandom_range(0, 1));
        if (p < 80)
        begin
            clock_now = clock_now + 64'($urandom_range(0, 3_000_000));
            c.now = clock_now;
            c.new_step_micros = $urandom_range(0, 9) == 0 ? 32'd0
                              : 32'($urandom_range(1000, 2_000_000));
            c.seek_step = $urandom_range(0, 500);
            c.song_steps = $urandom_range(0, 9) == 0 ? 16'd0
                         : 16'($urandom_range(1, 64));
        end
        else
        begin
            c.now = {$urandom(), $urandom()};
            c.new_step_micros = $urandom();
            c.seek_step = $urandom();
            c.song_steps = 16'($urandom());
        end
        return c;
    endfunction

    initial
    begin
        ptclk_pkg::cmd_t c;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corners
        send_gapped(make_cmd(ptclk_pkg::FUNC_PAUSE, 64'd10));   // pause while paused
        c = make_cmd(ptclk_pkg::FUNC_PLAY, 64'd1000);
        c.has_loop = 1'b1; c.new_loop = 1'b1;
        send_gapped(c);                                       // start, loop on
        send_gapped(make_cmd(ptclk_pkg::FUNC_PLAY, 64'd2000));  // play while playing
        c = make_cmd(ptclk_pkg::FUNC_ADJUST, 64'd7_000_000);
        c.has_loop = 1'b1; c.new_loop = 1'b0;
        send_gapped(c);                                       // loop realignment
        c = make_cmd(ptclk_pkg::FUNC_ADJUST, 64'd7_500_000);
        c.has_tempo = 1'b1; c.new_step_micros = 32'd333_333;
        send_gapped(c);                                       // retime, forward pos
        c = make_cmd(ptclk_pkg::FUNC_ADJUST, 64'd100);
        c.has_tempo = 1'b1; c.new_step_micros = ptclk_pkg::ALL32;
        send_gapped(c);                                       // retime, negative pos
        c = make_cmd(ptclk_pkg::FUNC_ADJUST, ptclk_pkg::ALL64);
        c.has_seek = 1'b1; c.seek_step = ptclk_pkg::ALL32;
        send_gapped(c);                                       // seek while playing
        c = make_cmd(ptclk_pkg::FUNC_ADJUST, 64'd0);
        c.has_tempo = 1'b1; c.new_step_micros = 32'd0;
        send_gapped(c);                                       // tempo to zero
        c = make_cmd(ptclk_pkg::FUNC_ADJUST, 64'd50);
        c.has_tempo = 1'b1; c.new_step_micros = 32'd1;
        send_gapped(c);                                       // retime from zero step
        send_gapped(make_cmd(ptclk_pkg::FUNC_PAUSE, ptclk_pkg::ALL64)); // capture saturates
        send_gapped(make_cmd(FUNC_UNUSED, 64'd5));              // unknown command
        c = make_cmd(ptclk_pkg::FUNC_ADJUST, 64'd5);
        c.has_seek = 1'b1; c.seek_step = 32'h5555_aaaa;
        send_gapped(c);                                       // seek while paused
        c = make_cmd(ptclk_pkg::FUNC_PLAY, 64'h8000_0000_0000_0000);
        c.has_tempo = 1'b1; c.new_step_micros = 32'haaaa_5555;
        c.has_seek = 1'b1; c.seek_step = 32'd3;
        send_gapped(c);
        send_gapped(make_cmd(ptclk_pkg::FUNC_PAUSE, 64'd0));    // now <= start
        c = make_cmd(ptclk_pkg::FUNC_PLAY, 64'h0123_4567_89ab_cdef);
        c.has_loop = 1'b1; c.new_loop = 1'b1;
        send_gapped(c);
        c = make_cmd(ptclk_pkg::FUNC_PAUSE, 64'hfedc_ba98_7654_3210);
        c.has_loop = 1'b1; c.new_loop = 1'b0; c.song_steps = 16'hffff;
        c.has_tempo = 1'b1; c.new_step_micros = 32'd500000;
        send_gapped(c);                                       // realign then pause

        // hold off until every response is back
        drain();

        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            if (i % 200 == 100)
                drain();
            send_gapped(random_cmd());
        end

        drain();
        repeat (DRAIN_WAIT) @(negedge clk);
        stim_done = 1'b1;
        $display("covered %0d commands, %0d responses checked", cmds_sent, rsps_seen);
        $display("play/pause/adjust with tempo, seek, loop realign and retime corners");
        if (fail_count == 0 && pending_count == 0)
            $display("playback_transport_clock verification clean");
        else
            $display("playback_transport_clock verification failed");
        $finish;
    end
endmodule
